@@ sv/bsss_pkg.sv @@
// Shared types and constants for the bilinear sample/splat image store.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package bsss_pkg;

  localparam int CMD_W      = 2;
  localparam int COORD_IN_W = 19;
  localparam int CH_SEL_W   = 2;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int CH_CNT_W   = 3;
  // internal coordinate width: covers integer parts and image sizes
  localparam int COORD_W    = 20;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPLAT  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST    = 10'd512;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST   = 10'd512;
  localparam logic [CH_CNT_W-1:0]   CHANNELS_RST = 3'd4;

  // control that travels with one neighbor access down the pipeline
  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic in_img;
    logic add_mode;
    logic first;
  } nb_ctl_t;

endpackage

`default_nettype wire

@@ sv/bsss_ifs.sv @@
// Handshake channel interfaces: item input, result output, register write.
// Depends on bsss_pkg for field widths.
`default_nettype none

interface bsss_in_if import bsss_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic signed [COORD_IN_W-1:0]  x_coord;
  logic signed [COORD_IN_W-1:0]  y_coord;
  logic [CH_SEL_W-1:0]           channel_sel;
  logic signed [DATA_W-1:0]      data_value;
  logic                          accumulate_mode;
  logic signed [DATA_W-1:0]      outside_value;

  modport source (output valid, command, x_coord, y_coord, channel_sel, data_value,
                  accumulate_mode, outside_value, input ready);
  modport sink (input valid, command, x_coord, y_coord, channel_sel, data_value,
                accumulate_mode, outside_value, output ready);
endinterface

interface bsss_out_if import bsss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     channel_invalid;

  modport source (output valid, result_value, channel_invalid, input ready);
  modport sink (input valid, result_value, channel_invalid, output ready);
endinterface

interface bsss_cfg_if import bsss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

@@ sv/bsss_wpipe.sv @@
// Weighting datapath: multiply stage, then round/saturate and accumulate stage.
// Produces the write-back word for splats and writes, and the item result.
`default_nettype none

module bsss_wpipe import bsss_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int AW        = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nb_ctl_t                  s1_ctl,
  input  logic [AW-1:0]            s1_addr,
  input  logic [2*FRAC_BITS:0]     s1_wt,
  input  logic signed [DATA_W-1:0] rd_data,
  input  logic signed [DATA_W-1:0] val,
  input  logic signed [DATA_W-1:0] outside,
  input  cmd_t                     cmd,
  output logic                     busy,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [DATA_W-1:0] wr_data,
  output logic signed [DATA_W-1:0] result
);

  localparam int SH  = 2 * FRAC_BITS;
  localparam int WTW = SH + 1;
  localparam int MW  = SH + 34;
  localparam logic [WTW-1:0]       WT_ONE = WTW'(1) << SH;
  localparam logic signed [MW-1:0] HALF   = MW'(1) << (SH - 1);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    hi = MW'($signed({1'b0, {(DATA_W-1){1'b1}}}));
    lo = MW'($signed({1'b1, {(DATA_W-1){1'b0}}}));
    if (v > hi) begin
      sat32 = hi[DATA_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[DATA_W-1:0];
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  logic signed [DATA_W-1:0] op_a;
  logic signed [WTW:0]      wt_s;
  logic signed [WTW:0]      inv_s;

  nb_ctl_t                  s2_ctl_r;
  logic [AW-1:0]            s2_addr_r;
  logic signed [DATA_W-1:0] s2_old_r;
  logic signed [MW-1:0]     s2_pa_r;
  logic signed [MW-1:0]     s2_pb_r;
  logic signed [MW-1:0]     acc_r;
  logic signed [DATA_W-1:0] rd_r;

  logic signed [MW-1:0]     add_q;
  logic signed [MW-1:0]     blend_q;
  logic signed [DATA_W-1:0] nv;

  // samples use the stored word when inside, the outside word otherwise
  always_comb begin
    if (s1_ctl.cmd == CMD_SAMPLE) begin
      op_a = s1_ctl.in_img ? rd_data : outside;
    end else begin
      op_a = val;
    end
    wt_s  = $signed({1'b0, s1_wt});
    inv_s = $signed({1'b0, WT_ONE - s1_wt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= s1_addr;
    s2_old_r  <= rd_data;
    s2_pa_r   <= MW'(wt_s) * MW'(op_a);
    s2_pb_r   <= MW'(inv_s) * MW'(rd_data);
  end

  always_comb begin
    add_q   = ((s2_pa_r + HALF) >>> SH) + MW'(s2_old_r);
    blend_q = (s2_pa_r + s2_pb_r + HALF) >>> SH;
    nv      = sat32(s2_ctl_r.add_mode ? add_q : blend_q);
  end

  assign busy    = s2_ctl_r.valid;
  assign wr_en   = s2_ctl_r.valid && ((s2_ctl_r.cmd == CMD_SPLAT && s2_ctl_r.in_img) ||
                                      s2_ctl_r.cmd == CMD_WRITE);
  assign wr_addr = s2_addr_r;
  assign wr_data = (s2_ctl_r.cmd == CMD_WRITE) ? val : nv;

  always_ff @(posedge clk) begin
    if (s2_ctl_r.valid && s2_ctl_r.cmd == CMD_SAMPLE) begin
      acc_r <= s2_ctl_r.first ? s2_pa_r : acc_r + s2_pa_r;
    end
    if (s2_ctl_r.valid && s2_ctl_r.cmd == CMD_READ) begin
      rd_r <= s2_old_r;
    end
  end

  always_comb begin
    unique case (cmd)
      CMD_SAMPLE: result = sat32((acc_r + HALF) >>> SH);
      CMD_READ:   result = rd_r;
      CMD_SPLAT,
      CMD_WRITE:  result = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/bilinear_sample_splat_store_unit.sv @@
// Bilinear sample/splat image store: top level with store memory and sequencer.
// Depends on bsss_pkg, bsss_ifs and bsss_wpipe.
// Splat and sample issue four neighbor accesses, read and write one; a new item is taken only once the last is done.
// The result word is valid once the item is done and is held while the next word enters.
// The four neighbors go through the single store memory one per cycle (one read, one write).
// After reset the store is zeroed, one word per cycle over all MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS
// words, during which no item is taken; register writes are taken throughout.
`default_nettype none

module bilinear_sample_splat_store_unit import bsss_pkg::*; #(
  parameter int MAX_WIDTH    = 512,
  parameter int MAX_HEIGHT   = 512,
  parameter int MAX_CHANNELS = 4,
  parameter int FRAC_BITS    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  bsss_cfg_if.sink      cfg_chan,
  bsss_in_if.sink       in_chan,
  bsss_out_if.source    out_chan
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WTW   = 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] WSCALE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                   state_r;
  logic [AW-1:0]            clr_cnt_r;
  logic [1:0]               nb_r;
  logic [CFG_DATA_W-1:0]    cfg_width_r;
  logic [CFG_DATA_W-1:0]    cfg_height_r;
  logic [CH_CNT_W-1:0]      cfg_ch_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_result_r;
  logic                     out_bad_r;

  // item held for the whole access sequence
  cmd_t                     cmd_r;
  logic signed [COORD_W-1:0] x0_r;
  logic signed [COORD_W-1:0] y0_r;
  logic [FRAC_BITS-1:0]     dx_r;
  logic [FRAC_BITS-1:0]     dy_r;
  logic [CH_SEL_W-1:0]      ch_eff_r;
  logic                     bad_r;
  logic                     add_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] outside_r;

  nb_ctl_t                  s1_ctl_r;
  logic [AW-1:0]            s1_addr_r;
  logic [WTW-1:0]           s1_wt_r;

  logic [DATA_W-1:0]        store_mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  // effective register values
  logic [15:0]              w16;
  logic [15:0]              h16;
  logic [XW:0]              w_eff;
  logic [YW:0]              h_eff;
  logic [CH_CNT_W-1:0]      nch;
  logic                     in_bad;
  logic signed [COORD_W-1:0] w_s;
  logic signed [COORD_W-1:0] h_s;

  // issue stage
  logic [FRAC_BITS:0]       wx;
  logic [FRAC_BITS:0]       wy;
  logic [WTW-1:0]           wt;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic                     pix_cmd;
  logic                     inside_nb;
  logic [XW-1:0]            ax;
  logic [YW-1:0]            ay;
  logic [AW-1:0]            issue_addr;
  nb_ctl_t                  issue_ctl;
  logic                     rd_en;

  logic                     wp_busy;
  logic                     wp_wr_en;
  logic [AW-1:0]            wp_wr_addr;
  logic signed [DATA_W-1:0] wp_wr_data;
  logic signed [DATA_W-1:0] wp_result;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;

  always_comb begin
    w16 = 16'(cfg_width_r);
    h16 = 16'(cfg_height_r);
    if (w16 == 16'd0) begin
      w_eff = (XW+1)'(1);
    end else if (w16 > 16'(MAX_WIDTH)) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(w16);
    end
    if (h16 == 16'd0) begin
      h_eff = (YW+1)'(1);
    end else if (h16 > 16'(MAX_HEIGHT)) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(h16);
    end
    if (cfg_ch_r == '0) begin
      nch = CH_CNT_W'(1);
    end else if (cfg_ch_r > CH_CNT_W'(MAX_CHANNELS)) begin
      nch = CH_CNT_W'(MAX_CHANNELS);
    end else begin
      nch = cfg_ch_r;
    end
    in_bad = CH_CNT_W'(in_chan.channel_sel) >= nch;
    w_s    = $signed(COORD_W'(w_eff));
    h_s    = $signed(COORD_W'(h_eff));
  end

  always_comb begin
    wx = nb_r[0] ? {1'b0, dx_r} : WSCALE - {1'b0, dx_r};
    wy = nb_r[1] ? {1'b0, dy_r} : WSCALE - {1'b0, dy_r};
    wt = WTW'(wx) * WTW'(wy);
    px = x0_r + $signed(COORD_W'(nb_r[0]));
    py = y0_r + $signed(COORD_W'(nb_r[1]));
    inside_nb = !bad_r && !px[COORD_W-1] && (px < w_s) && !py[COORD_W-1] && (py < h_s);
    // pixel commands clamp into the image
    if (x0_r[COORD_W-1]) begin
      cx = '0;
    end else if (x0_r >= w_s) begin
      cx = w_s - COORD_W'(1);
    end else begin
      cx = x0_r;
    end
    if (y0_r[COORD_W-1]) begin
      cy = '0;
    end else if (y0_r >= h_s) begin
      cy = h_s - COORD_W'(1);
    end else begin
      cy = y0_r;
    end
    pix_cmd = (cmd_r == CMD_WRITE) || (cmd_r == CMD_READ);
    ax = pix_cmd ? cx[XW-1:0] : px[XW-1:0];
    ay = pix_cmd ? cy[YW-1:0] : py[YW-1:0];
    issue_addr = AW'((AW'(ay) * AW'(MAX_WIDTH) + AW'(ax)) * AW'(MAX_CHANNELS) +
                     AW'(ch_eff_r));
    issue_ctl.valid    = (state_r == ST_ISSUE);
    issue_ctl.cmd      = cmd_r;
    issue_ctl.in_img   = pix_cmd ? 1'b1 : inside_nb;
    issue_ctl.add_mode = add_r;
    issue_ctl.first    = (nb_r == 2'd0);
    rd_en = issue_ctl.valid && issue_ctl.in_img && (cmd_r != CMD_WRITE);
  end

  assign mem_we    = (state_r == ST_CLEAR) || wp_wr_en;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : wp_wr_addr;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : wp_wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[issue_addr];
    end
  end

  bsss_wpipe #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_wpipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_ctl  (s1_ctl_r),
    .s1_addr (s1_addr_r),
    .s1_wt   (s1_wt_r),
    .rd_data (rd_data_r),
    .val     (val_r),
    .outside (outside_r),
    .cmd     (cmd_r),
    .busy    (wp_busy),
    .wr_en   (wp_wr_en),
    .wr_addr (wp_wr_addr),
    .wr_data (wp_wr_data),
    .result  (wp_result)
  );

  assign in_chan.ready            = (state_r == ST_IDLE);
  assign cfg_chan.ready           = 1'b1;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.result_value    = out_result_r;
  assign out_chan.channel_invalid = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      nb_r         <= '0;
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_ch_r     <= CHANNELS_RST;
      out_valid_r  <= 1'b0;
      s1_ctl_r     <= '0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.addr)
          REG_WIDTH:    cfg_width_r  <= cfg_chan.wdata;
          REG_HEIGHT:   cfg_height_r <= cfg_chan.wdata;
          REG_CHANNELS: cfg_ch_r     <= cfg_chan.wdata[CH_CNT_W-1:0];
          default:      ;
        endcase
      end
      s1_ctl_r <= issue_ctl;
      // FINISH reloads the output register on its own
      if (out_valid_r && out_chan.ready && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_chan.valid) begin
            nb_r    <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          nb_r <= nb_r + 2'd1;
          if (pix_cmd || nb_r == 2'd3) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_ctl_r.valid && !wp_busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the output register frees up
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_result_r <= wp_result;
            out_bad_r    <= bad_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_chan.valid) begin
      cmd_r     <= cmd_t'(in_chan.command);
      x0_r      <= COORD_W'(in_chan.x_coord) >>> FRAC_BITS;
      y0_r      <= COORD_W'(in_chan.y_coord) >>> FRAC_BITS;
      dx_r      <= in_chan.x_coord[FRAC_BITS-1:0];
      dy_r      <= in_chan.y_coord[FRAC_BITS-1:0];
      bad_r     <= in_bad;
      ch_eff_r  <= in_bad ? CH_SEL_W'(nch - CH_CNT_W'(1)) : in_chan.channel_sel;
      add_r     <= in_chan.accumulate_mode;
      val_r     <= in_chan.data_value;
      outside_r <= in_chan.outside_value;
    end
    s1_addr_r <= issue_addr;
    s1_wt_r   <= wt;
  end

  // neighbor write-back never lands on the word being read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_wr_en && rd_en) |-> (wp_wr_addr != issue_addr))
    else $error("write-back collides with a read of the same word");

  a_finish_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (!s1_ctl_r.valid && !wp_busy))
    else $error("result taken while neighbor accesses are still in flight");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_waddr <= AW'(DEPTH - 1)))
    else $error("store write beyond the memory depth");

  a_pixel_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE && (cmd_r == CMD_WRITE || cmd_r == CMD_READ)) |-> (nb_r == 2'd0))
    else $error("pixel command issued more than one access");

endmodule

`default_nettype wire
